// ----- src/sam_pkg.sv -----
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types and constants for the sensor alarm monitor: alarm modes,
// register map, sample layout and threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sam_pkg;

  // samples forced to normal after reset, and fixed hysteresis bands
  localparam int START_SAMPLES = 10;
  localparam int TEMP_BAND     = 50;
  localparam int HUMID_HYST    = 50;

  localparam int SETTLE_W = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_WARNING = 2'd1,
    MODE_FAULT   = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_VOLT_LOW   = 3'd0,
    REG_VOLT_HIGH  = 3'd1,
    REG_CURR_HIGH  = 3'd2,
    REG_TEMP_HIGH  = 3'd3,
    REG_HUMID_LOW  = 3'd4,
    REG_HUMID_HIGH = 3'd5,
    REG_VOLT_MARG  = 3'd6,
    REG_CURR_MARG  = 3'd7
  } reg_idx_t;

  // volt in the lowest bits, humid in the highest
  typedef struct packed {
    logic        [9:0]  humid;
    logic signed [11:0] temp;
    logic        [15:0] curr;
    logic        [15:0] volt;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);

  typedef struct packed {
    logic        [15:0] volt_low_limit;
    logic        [15:0] volt_high_limit;
    logic        [15:0] curr_high_limit;
    logic signed [11:0] temp_high_limit;
    logic        [9:0]  humid_low_limit;
    logic        [9:0]  humid_high_limit;
    logic        [15:0] volt_margin;
    logic        [15:0] curr_margin;
  } cfg_t;

  typedef struct packed {
    logic warn;
    logic fault;
  } flags_t;

  localparam logic [15:0] VOLT_LOW_RST   = 16'd10000;
  localparam logic [15:0] VOLT_HIGH_RST  = 16'd14000;
  localparam logic [15:0] CURR_HIGH_RST  = 16'd5000;
  localparam logic [11:0] TEMP_HIGH_RST  = 12'd600;
  localparam logic [9:0]  HUMID_LOW_RST  = 10'd200;
  localparam logic [9:0]  HUMID_HIGH_RST = 10'd800;
  localparam logic [15:0] VOLT_MARG_RST  = 16'd500;
  localparam logic [15:0] CURR_MARG_RST  = 16'd500;

endpackage

`default_nettype wire

// ----- src/sam_threshold.sv -----
// ----------------------------------------------------------------------------
// sam_threshold
// Comparator bank: checks one sample against the warning limits and the
// fault limits (warning limits widened by margin, band or hysteresis) on all channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sam_threshold (
  input  wire sam_pkg::sample_t sample,
  input  wire sam_pkg::cfg_t    cfg,
  output sam_pkg::flags_t       flags
);

  localparam logic signed [12:0] TEMP_BAND_S  = 13'(sam_pkg::TEMP_BAND);
  localparam logic signed [11:0] HUMID_HYST_S = 12'(sam_pkg::HUMID_HYST);

  // widened so that limit minus margin and limit plus margin cannot wrap
  logic signed [17:0] v_s, vl_s, vh_s, vm_s, i_s, ch_s, cm_s;
  logic signed [12:0] t_s, th_s;
  logic signed [11:0] h_s, hl_s, hh_s;

  logic volt_warn, volt_fault, curr_warn, curr_fault;
  logic temp_warn, temp_fault, humid_warn, humid_fault;

  assign v_s  = $signed({2'b00, sample.volt});
  assign vl_s = $signed({2'b00, cfg.volt_low_limit});
  assign vh_s = $signed({2'b00, cfg.volt_high_limit});
  assign vm_s = $signed({2'b00, cfg.volt_margin});
  assign i_s  = $signed({2'b00, sample.curr});
  assign ch_s = $signed({2'b00, cfg.curr_high_limit});
  assign cm_s = $signed({2'b00, cfg.curr_margin});
  assign t_s  = $signed({sample.temp[11], sample.temp});
  assign th_s = $signed({cfg.temp_high_limit[11], cfg.temp_high_limit});
  assign h_s  = $signed({2'b00, sample.humid});
  assign hl_s = $signed({2'b00, cfg.humid_low_limit});
  assign hh_s = $signed({2'b00, cfg.humid_high_limit});

  assign volt_warn   = (v_s < vl_s) || (v_s > vh_s);
  assign volt_fault  = (v_s < (vl_s - vm_s)) || (v_s > (vh_s + vm_s));
  assign curr_warn   = i_s > ch_s;
  assign curr_fault  = i_s > (ch_s + cm_s);
  assign temp_warn   = t_s > th_s;
  assign temp_fault  = t_s > (th_s + TEMP_BAND_S);
  assign humid_warn  = (h_s < hl_s) || (h_s > hh_s);
  assign humid_fault = (h_s < (hl_s - HUMID_HYST_S)) || (h_s > (hh_s + HUMID_HYST_S));

  assign flags.warn  = volt_warn || curr_warn || temp_warn || humid_warn;
  assign flags.fault = volt_fault || curr_fault || temp_fault || humid_fault;

endmodule

`default_nettype wire

// ----- src/sensor_alarm_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_alarm_monitor_unit
// Takes one sensor sample or heartbeat timeout per transfer and returns the
// alarm mode with its lamp and buzzer outputs. One item is accepted every
// clock cycle while the input is not stalled; each result passes through
// the input register and is then held in the alarm state register, which
// also serves as the output register. Back-pressure on the result side
// stalls the input side only once both registers are full. The
// first ten samples after reset report normal; a timeout reports error at
// once, and the next settled sample returns to normal. Thresholds are set
// through the APB port and should be written while no transfer is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_alarm_monitor_unit (
  input  wire                         clk,
  input  wire                         rst,
  // slave side
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [55:0]                 s_tdata,   // volt[15:0] curr[31:16] temp[43:32]
                                                 // humid[53:44], zero pad[55:54]
  input  wire                         s_tuser,   // req_type: 1 heartbeat timeout
  // master side
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [7:0]                  m_tdata,   // mode[1:0] led_on[2] beeper_on[3]
                                                 // zero pad[7:4]
  // configuration
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [sam_pkg::ADDR_W-1:0]  paddr,
  input  wire  [sam_pkg::DATA_W-1:0]  pwdata,
  output logic [sam_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam logic [sam_pkg::SETTLE_W-1:0] SETTLE_DONE =
    sam_pkg::SETTLE_W'(sam_pkg::START_SAMPLES);

  // configuration registers
  sam_pkg::cfg_t     cfg;
  sam_pkg::reg_idx_t reg_idx;
  logic              cfg_write;

  // input register
  logic              in_valid;
  logic              in_type;
  sam_pkg::sample_t  in_sample;

  // state / output register
  logic                         out_valid;
  sam_pkg::mode_t               alarm_mode, alarm_mode_next;
  logic [sam_pkg::SETTLE_W-1:0] settle_count, settle_count_next;

  logic             out_free;
  logic             advance;
  logic             led_on, beeper_on;
  sam_pkg::flags_t  flags;

  assign pready    = 1'b1;
  assign reg_idx   = sam_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_low_limit   <= sam_pkg::VOLT_LOW_RST;
      cfg.volt_high_limit  <= sam_pkg::VOLT_HIGH_RST;
      cfg.curr_high_limit  <= sam_pkg::CURR_HIGH_RST;
      cfg.temp_high_limit  <= sam_pkg::TEMP_HIGH_RST;
      cfg.humid_low_limit  <= sam_pkg::HUMID_LOW_RST;
      cfg.humid_high_limit <= sam_pkg::HUMID_HIGH_RST;
      cfg.volt_margin      <= sam_pkg::VOLT_MARG_RST;
      cfg.curr_margin      <= sam_pkg::CURR_MARG_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        sam_pkg::REG_VOLT_LOW:   cfg.volt_low_limit   <= pwdata[15:0];
        sam_pkg::REG_VOLT_HIGH:  cfg.volt_high_limit  <= pwdata[15:0];
        sam_pkg::REG_CURR_HIGH:  cfg.curr_high_limit  <= pwdata[15:0];
        sam_pkg::REG_TEMP_HIGH:  cfg.temp_high_limit  <= pwdata[11:0];
        sam_pkg::REG_HUMID_LOW:  cfg.humid_low_limit  <= pwdata[9:0];
        sam_pkg::REG_HUMID_HIGH: cfg.humid_high_limit <= pwdata[9:0];
        sam_pkg::REG_VOLT_MARG:  cfg.volt_margin      <= pwdata[15:0];
        sam_pkg::REG_CURR_MARG:  cfg.curr_margin      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sam_pkg::REG_VOLT_LOW:   prdata = 32'(cfg.volt_low_limit);
      sam_pkg::REG_VOLT_HIGH:  prdata = 32'(cfg.volt_high_limit);
      sam_pkg::REG_CURR_HIGH:  prdata = 32'(cfg.curr_high_limit);
      sam_pkg::REG_TEMP_HIGH:  prdata = {20'd0, cfg.temp_high_limit};
      sam_pkg::REG_HUMID_LOW:  prdata = 32'(cfg.humid_low_limit);
      sam_pkg::REG_HUMID_HIGH: prdata = 32'(cfg.humid_high_limit);
      sam_pkg::REG_VOLT_MARG:  prdata = 32'(cfg.volt_margin);
      sam_pkg::REG_CURR_MARG:  prdata = 32'(cfg.curr_margin);
      default:                 prdata = '0;
    endcase
  end

  // pipeline handshake
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type   <= s_tuser;
      in_sample <= sam_pkg::sample_t'(s_tdata[sam_pkg::SAMPLE_W-1:0]);
    end
  end

  sam_threshold u_threshold (
    .sample (in_sample),
    .cfg    (cfg),
    .flags  (flags)
  );

  // next state
  always_comb begin
    alarm_mode_next   = alarm_mode;
    settle_count_next = settle_count;
    if (advance) begin
      if (in_type) begin
        alarm_mode_next = sam_pkg::MODE_ERROR;
      end else if (settle_count < SETTLE_DONE) begin
        settle_count_next = settle_count + 1'b1;
        alarm_mode_next   = sam_pkg::MODE_NORMAL;
      end else begin
        case (alarm_mode)
          sam_pkg::MODE_NORMAL: begin
            if (flags.fault) begin
              alarm_mode_next = sam_pkg::MODE_FAULT;
            end else if (flags.warn) begin
              alarm_mode_next = sam_pkg::MODE_WARNING;
            end
          end
          sam_pkg::MODE_WARNING: begin
            if (flags.fault) begin
              alarm_mode_next = sam_pkg::MODE_FAULT;
            end else if (!flags.warn) begin
              alarm_mode_next = sam_pkg::MODE_NORMAL;
            end
          end
          sam_pkg::MODE_FAULT: begin
            if (!flags.fault) begin
              alarm_mode_next = flags.warn ? sam_pkg::MODE_WARNING : sam_pkg::MODE_NORMAL;
            end
          end
          default: alarm_mode_next = sam_pkg::MODE_NORMAL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_mode   <= sam_pkg::MODE_NORMAL;
      settle_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      alarm_mode   <= alarm_mode_next;
      settle_count <= settle_count_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // outputs
  always_comb begin
    led_on    = alarm_mode != sam_pkg::MODE_NORMAL;
    beeper_on = (alarm_mode == sam_pkg::MODE_FAULT) || (alarm_mode == sam_pkg::MODE_ERROR);
    m_tvalid  = out_valid;
    m_tdata   = {4'b0000, beeper_on, led_on, alarm_mode};
  end

  a_timeout_error: assert property (@(posedge clk) disable iff (rst)
    advance && in_type |=> alarm_mode == sam_pkg::MODE_ERROR)
    else $error("timeout did not give error mode");

  a_settle_normal: assert property (@(posedge clk) disable iff (rst)
    advance && !in_type && settle_count < SETTLE_DONE |=> alarm_mode == sam_pkg::MODE_NORMAL)
    else $error("settling sample did not give normal mode");

  a_settle_bound: assert property (@(posedge clk) disable iff (rst)
    settle_count <= SETTLE_DONE)
    else $error("settle count ran past its limit");

  a_settle_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(settle_count) && $stable(alarm_mode))
    else $error("state moved without a transfer");

  a_error_exit: assert property (@(posedge clk) disable iff (rst)
    advance && !in_type && alarm_mode == sam_pkg::MODE_ERROR |=>
      alarm_mode == sam_pkg::MODE_NORMAL)
    else $error("sample in error mode did not return to normal");

endmodule

`default_nettype wire
